// ===== sv/ssat_pkg.sv =====
// ----------------------------------------------------------------------------
// ssat_pkg
// Types and constants for the shell-style argument tokenizer.
// ----------------------------------------------------------------------------
package ssat_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_LINE_END = 2'd2
  } kind_t;

  localparam logic [9:0] WORD_LIMIT_RESET = 10'd997;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // pair: a word end goes out ahead of this line end
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [9:0]  count;
    logic        ovf;
    logic        pair;
  } result_t;

endpackage

// ===== sv/shell_style_arg_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shell_style_arg_tokenizer
// Splits a byte stream into shell-like words with quotes and escapes.
// ----------------------------------------------------------------------------
// Input channel: one byte (char_byte) or an end-of-line mark (line_end) per
// transfer, qualified by in_valid / in_stall. Output channel: results of kind
// word byte, word end or line end, qualified by out_valid / out_stall, with
// last_of_run set on the final result of each input transfer.
// word_limit is written through cfg_write / cfg_data; the user must do so
// only while the block is idle, and the block itself does no check on it.
// The parse state is updated in the cycle a byte is taken, and its result is
// placed in a two-entry output queue. One byte is taken every cycle while the
// queue has room. A line end that closes a pending word gives two output
// transfers (word end, then line end) from the same queue entry, the only case
// in which one input transfer gives more than one result. Bytes giving no
// result (separators between words, quotes, backslashes, anything after
// overflow) are taken and produce nothing.
// Reset clears the parse state and the queue and loads word_limit with 997.
// When the receiver stalls, the queue fills and in_stall rises once it holds
// two entries; the shown result holds steady until taken.
// ----------------------------------------------------------------------------
module shell_style_arg_tokenizer #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_byte,
  input  logic               line_end,
  output logic               out_valid,
  input  logic               out_stall,
  output ssat_pkg::kind_t    kind,
  output logic [7:0]         out_byte,
  output logic [9:0]         word_count,
  output logic               overflow,
  output logic               last_of_run
);
  import ssat_pkg::*;

  localparam int CMP_W = COUNT_WIDTH + 11;

  typedef enum logic [2:0] {
    M_SKIP    = 3'd0,
    M_TOK     = 3'd1,
    M_Q1      = 3'd2,
    M_Q2      = 3'd3,
    M_Q1_ESC  = 3'd4,
    M_Q2_ESC  = 3'd5,
    M_TOK_ESC = 3'd6
  } mode_t;

  logic [9:0]             word_limit;
  mode_t                  mode, mode_next;
  logic                   word_open, word_open_next;
  logic [COUNT_WIDTH-1:0] words_seen, words_seen_next;
  logic                   overflowed, overflowed_next;

  result_t                slots [2];
  logic                   wr_ptr, rd_ptr;
  logic [1:0]             fill;
  logic                   phase;

  logic                   accept, pop, push;
  result_t                entry, head;
  logic                   ws;
  logic [COUNT_WIDTH:0]   inc;
  logic [COUNT_WIDTH-1:0] sat;
  logic                   limit_hit;
  logic [COUNT_WIDTH+9:0] seen_wide, sat_wide;

  assign ws = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
              (char_byte == CH_CR) || (char_byte == CH_LF);

  assign inc       = {1'b0, words_seen} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign sat       = inc[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : inc[COUNT_WIDTH-1:0];
  assign limit_hit = CMP_W'(inc) > CMP_W'(word_limit);
  assign seen_wide = {10'd0, words_seen};
  assign sat_wide  = {10'd0, sat};

  assign in_stall = (fill == 2'd2);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mode_next       = mode;
    word_open_next  = word_open;
    words_seen_next = words_seen;
    overflowed_next = overflowed;
    push            = 1'b0;
    entry.kind      = KIND_BYTE;
    entry.data      = char_byte;
    entry.count     = seen_wide[9:0];
    entry.ovf       = overflowed;
    entry.pair      = 1'b0;

    if (line_end) begin
      push            = 1'b1;
      entry.kind      = KIND_LINE_END;
      entry.data      = 8'd0;
      entry.pair      = word_open;
      entry.count     = word_open ? sat_wide[9:0] : seen_wide[9:0];
      mode_next       = M_SKIP;
      word_open_next  = 1'b0;
      words_seen_next = '0;
      overflowed_next = 1'b0;
    end else if (!overflowed) begin
      case (mode)
        M_Q1: begin
          if (char_byte == CH_SQUOTE) mode_next = M_TOK;
          else if (char_byte == CH_BSLASH) mode_next = M_Q1_ESC;
          else begin
            push           = 1'b1;
            word_open_next = 1'b1;
          end
        end
        M_Q2: begin
          if (char_byte == CH_DQUOTE) mode_next = M_TOK;
          else if (char_byte == CH_BSLASH) mode_next = M_Q2_ESC;
          else begin
            push           = 1'b1;
            word_open_next = 1'b1;
          end
        end
        M_Q1_ESC, M_Q2_ESC, M_TOK_ESC: begin
          mode_next      = (mode == M_Q1_ESC) ? M_Q1 :
                           (mode == M_Q2_ESC) ? M_Q2 : M_TOK;
          push           = 1'b1;
          word_open_next = 1'b1;
        end
        default: begin
          if (mode != M_TOK && ws) begin
            mode_next = M_SKIP;
          end else if (char_byte == CH_SQUOTE) begin
            mode_next = M_Q1;
          end else if (char_byte == CH_DQUOTE) begin
            mode_next = M_Q2;
          end else if (char_byte == CH_BSLASH) begin
            mode_next = M_TOK_ESC;
          end else if (ws) begin
            mode_next = M_SKIP;
            if (word_open) begin
              push            = 1'b1;
              word_open_next  = 1'b0;
              words_seen_next = sat;
              overflowed_next = limit_hit;
              entry.kind      = KIND_WORD_END;
              entry.data      = 8'd0;
              entry.count     = sat_wide[9:0];
              entry.ovf       = limit_hit;
            end
          end else begin
            mode_next      = M_TOK;
            push           = 1'b1;
            word_open_next = 1'b1;
          end
        end
      endcase
    end
  end

  // output queue: head entry drives the port, a pair entry takes two transfers
  assign head        = slots[rd_ptr];
  assign out_valid   = (fill != 2'd0);
  assign kind        = (head.pair && !phase) ? KIND_WORD_END : head.kind;
  assign out_byte    = head.data;
  assign word_count  = head.count;
  assign overflow    = head.ovf;
  assign last_of_run = !(head.pair && !phase);
  assign pop         = out_valid && !out_stall && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit <= WORD_LIMIT_RESET;
      mode       <= M_SKIP;
      word_open  <= 1'b0;
      words_seen <= '0;
      overflowed <= 1'b0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fill       <= 2'd0;
      phase      <= 1'b0;
    end else begin
      if (cfg_write) word_limit <= cfg_data;
      if (accept) begin
        mode       <= mode_next;
        word_open  <= word_open_next;
        words_seen <= words_seen_next;
        overflowed <= overflowed_next;
      end
      if (accept && push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, accept && push} - {1'b0, pop};
      if (out_valid && !out_stall) phase <= head.pair && !phase;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) slots[wr_ptr] <= entry;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2)
    else $error("output queue overfilled");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    accept && line_end |=> words_seen == '0 && !overflowed && !word_open)
    else $error("line state not cleared after line end");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflowed && !(accept && line_end) |=> overflowed)
    else $error("overflow dropped inside a line");

  a_phase_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> out_valid && head.pair)
    else $error("second half shown without a pair entry");

  a_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> kind == KIND_WORD_END)
    else $error("non-final result is not a word end");
`endif

endmodule
